>>> rtl/lcg_pkg.sv
// ----------------------------------------------------------------------------
// lcg_pkg
// Shared types, constants and the microcode table of the variate generator.
// ----------------------------------------------------------------------------
package lcg_pkg;

	localparam int WORD_BITS    = 32;
	localparam int FRAC_BITS    = 32;
	localparam int VARIATE_BITS = 36;
	localparam int STEP_BITS    = 4;
	localparam int COUNT_BITS   = 8;

	localparam logic [WORD_BITS-1:0]    LCG_MULT  = 32'd1566083941;
	localparam logic [WORD_BITS-1:0]    LCG_INC   = 32'd1;
	localparam logic [WORD_BITS-1:0]    RESET_STATE = 32'd1;
	localparam logic [VARIATE_BITS-1:0] NORMAL_INIT = 36'hA_0000_0000;
	localparam logic [COUNT_BITS-1:0]   NORMAL_LOOP = 8'd10;

	typedef enum logic [2:0] {
		MODE_UNIFORM    = 3'd0,
		MODE_TRIANGULAR = 3'd1,
		MODE_POWER      = 3'd2,
		MODE_NORMAL     = 3'd3,
		MODE_RESEED     = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		ACC_HOLD = 3'd0,
		ACC_LOAD = 3'd1,
		ACC_SUB  = 3'd2,
		ACC_MAX  = 3'd3,
		ACC_ADD  = 3'd4,
		ACC_NORM = 3'd5
	} acc_op_t;

	typedef enum logic [1:0] {
		CNT_HOLD  = 2'd0,
		CNT_ORDER = 2'd1,
		CNT_NORM  = 2'd2,
		CNT_DEC   = 2'd3
	} cnt_op_t;

	typedef enum logic [1:0] {
		JMP_NONE = 2'd0,
		JMP_NZ   = 2'd1,
		JMP_Z    = 2'd2
	} jmp_t;

	// Program entry points and jump targets.
	localparam logic [STEP_BITS-1:0] PC_UNIFORM = 4'd0;
	localparam logic [STEP_BITS-1:0] PC_TRI     = 4'd2;
	localparam logic [STEP_BITS-1:0] PC_POWER   = 4'd5;
	localparam logic [STEP_BITS-1:0] PC_PLOOP   = 4'd7;
	localparam logic [STEP_BITS-1:0] PC_PEMIT   = 4'd9;
	localparam logic [STEP_BITS-1:0] PC_NORMAL  = 4'd10;
	localparam logic [STEP_BITS-1:0] PC_NLOOP   = 4'd11;
	localparam logic [STEP_BITS-1:0] PC_RESEED  = 4'd13;
	localparam logic [STEP_BITS-1:0] PC_LAST    = 4'd13;

	typedef struct packed {
		logic                 draw;
		logic                 seed_ld;
		acc_op_t              acc_op;
		cnt_op_t              cnt_op;
		jmp_t                 jmp;
		logic [STEP_BITS-1:0] target;
		logic                 emit;
		logic                 fin;
	} ctrl_word_t;

	typedef struct packed {
		logic       start;
		logic       step_en;
		ctrl_word_t word;
	} seq_ctrl_t;

	typedef struct packed {
		logic cnt_zero;
		logic out_full;
	} dp_status_t;

	function automatic ctrl_word_t rom_word(input logic [STEP_BITS-1:0] pc);
		ctrl_word_t w;
		w = '{1'b0, 1'b0, ACC_HOLD, CNT_HOLD, JMP_NONE, 4'd0, 1'b0, 1'b0};
		case (pc)
			4'd0: begin
				w.draw = 1'b1;
			end
			4'd1: begin
				w.acc_op = ACC_LOAD;
				w.emit   = 1'b1;
				w.fin    = 1'b1;
			end
			4'd2: begin
				w.draw = 1'b1;
			end
			4'd3: begin
				w.draw   = 1'b1;
				w.acc_op = ACC_LOAD;
			end
			4'd4: begin
				w.acc_op = ACC_SUB;
				w.emit   = 1'b1;
				w.fin    = 1'b1;
			end
			4'd5: begin
				w.draw   = 1'b1;
				w.cnt_op = CNT_ORDER;
			end
			4'd6: begin
				w.acc_op = ACC_LOAD;
				w.jmp    = JMP_Z;
				w.target = PC_PEMIT;
			end
			4'd7: begin
				w.draw   = 1'b1;
				w.cnt_op = CNT_DEC;
			end
			4'd8: begin
				w.acc_op = ACC_MAX;
				w.jmp    = JMP_NZ;
				w.target = PC_PLOOP;
			end
			4'd9: begin
				w.emit = 1'b1;
				w.fin  = 1'b1;
			end
			4'd10: begin
				w.draw   = 1'b1;
				w.acc_op = ACC_NORM;
				w.cnt_op = CNT_NORM;
			end
			4'd11: begin
				w.draw   = 1'b1;
				w.acc_op = ACC_ADD;
				w.cnt_op = CNT_DEC;
				w.jmp    = JMP_NZ;
				w.target = PC_NLOOP;
			end
			4'd12: begin
				w.acc_op = ACC_ADD;
				w.emit   = 1'b1;
				w.fin    = 1'b1;
			end
			4'd13: begin
				w.seed_ld = 1'b1;
				w.fin     = 1'b1;
			end
			default: begin
				w.fin = 1'b1;
			end
		endcase
		return w;
	endfunction

endpackage

>>> rtl/lcg_sequencer.sv
// ----------------------------------------------------------------------------
// lcg_sequencer
// Step counter and microcode table; decodes each request into a program.
// ----------------------------------------------------------------------------
module lcg_sequencer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic [2:0]          req_mode,
	output logic                req_ready,
	input  lcg_pkg::dp_status_t status,
	output lcg_pkg::seq_ctrl_t  ctrl
);

	logic                          busy_q;
	logic [lcg_pkg::STEP_BITS-1:0] pc_q;
	logic [lcg_pkg::STEP_BITS-1:0] entry;
	logic                          entry_ok;
	logic                          take_jump;
	lcg_pkg::ctrl_word_t           word;

	assign word      = lcg_pkg::rom_word(pc_q);
	assign req_ready = !busy_q;

	always_comb begin
		entry_ok = 1'b1;
		entry    = lcg_pkg::PC_UNIFORM;
		case (req_mode)
			lcg_pkg::MODE_UNIFORM:    entry = lcg_pkg::PC_UNIFORM;
			lcg_pkg::MODE_TRIANGULAR: entry = lcg_pkg::PC_TRI;
			lcg_pkg::MODE_POWER:      entry = lcg_pkg::PC_POWER;
			lcg_pkg::MODE_NORMAL:     entry = lcg_pkg::PC_NORMAL;
			lcg_pkg::MODE_RESEED:     entry = lcg_pkg::PC_RESEED;
			default:                  entry_ok = 1'b0;
		endcase
	end

	always_comb begin
		case (word.jmp)
			lcg_pkg::JMP_NZ: take_jump = !status.cnt_zero;
			lcg_pkg::JMP_Z:  take_jump = status.cnt_zero;
			default:         take_jump = 1'b0;
		endcase
	end

	assign ctrl.start   = req_valid && !busy_q && entry_ok;
	assign ctrl.step_en = busy_q && !(word.emit && status.out_full);
	assign ctrl.word    = word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= '0;
		end else if (ctrl.start) begin
			busy_q <= 1'b1;
			pc_q   <= entry;
		end else if (ctrl.step_en) begin
			if (word.fin) begin
				busy_q <= 1'b0;
			end else if (take_jump) begin
				pc_q <= word.target;
			end else begin
				pc_q <= pc_q + 1'b1;
			end
		end
	end

	// The program counter never leaves the microcode program.
	a_pc_in_program: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> pc_q <= lcg_pkg::PC_LAST)
		else $error("sequencer ran past the end of the program");

	// A started request keeps the sequencer busy in the following cycle.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.start |=> busy_q)
		else $error("request started but sequencer not busy");

	// A finishing step hands the sequencer back to idle.
	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.step_en && word.fin |=> !busy_q && req_ready)
		else $error("sequencer still busy after final step");

endmodule

>>> rtl/lcg_datapath.sv
// ----------------------------------------------------------------------------
// lcg_datapath
// Generator state, accumulator, loop counter and the result register.
// ----------------------------------------------------------------------------
module lcg_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  lcg_pkg::seq_ctrl_t                   ctrl,
	input  logic [lcg_pkg::WORD_BITS-1:0]        seed_value,
	input  logic [lcg_pkg::COUNT_BITS-1:0]       power_order,
	input  logic                                 out_ready,
	output logic                                 out_valid,
	output logic [lcg_pkg::VARIATE_BITS-1:0]     variate,
	output lcg_pkg::dp_status_t                  status
);

	logic [lcg_pkg::WORD_BITS-1:0]    state_q;
	logic [lcg_pkg::WORD_BITS-1:0]    seed_q;
	logic [lcg_pkg::WORD_BITS-1:0]    state_next;
	logic [lcg_pkg::VARIATE_BITS-1:0] acc_q;
	logic [lcg_pkg::VARIATE_BITS-1:0] acc_d;
	logic [lcg_pkg::VARIATE_BITS-1:0] u_ext;
	logic [lcg_pkg::COUNT_BITS-1:0]   cnt_q;
	logic                             out_valid_q;
	logic [lcg_pkg::VARIATE_BITS-1:0] out_data_q;

	assign state_next = state_q * lcg_pkg::LCG_MULT + lcg_pkg::LCG_INC;
	assign u_ext = {{(lcg_pkg::VARIATE_BITS - lcg_pkg::FRAC_BITS){1'b0}},
		state_q[lcg_pkg::WORD_BITS-1 -: lcg_pkg::FRAC_BITS]};

	always_comb begin
		case (ctrl.word.acc_op)
			lcg_pkg::ACC_LOAD: acc_d = u_ext;
			lcg_pkg::ACC_SUB:  acc_d = acc_q - u_ext;
			lcg_pkg::ACC_MAX:  acc_d = (u_ext > acc_q) ? u_ext : acc_q;
			lcg_pkg::ACC_ADD:  acc_d = acc_q + u_ext;
			lcg_pkg::ACC_NORM: acc_d = lcg_pkg::NORMAL_INIT;
			default:           acc_d = acc_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lcg_pkg::RESET_STATE;
		end else if (ctrl.step_en && ctrl.word.seed_ld) begin
			state_q <= seed_q;
		end else if (ctrl.step_en && ctrl.word.draw) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			seed_q <= seed_value;
		end
		if (ctrl.step_en) begin
			acc_q <= acc_d;
			case (ctrl.word.cnt_op)
				lcg_pkg::CNT_ORDER: cnt_q <= power_order;
				lcg_pkg::CNT_NORM:  cnt_q <= lcg_pkg::NORMAL_LOOP;
				lcg_pkg::CNT_DEC:   cnt_q <= cnt_q - 1'b1;
				default:            cnt_q <= cnt_q;
			endcase
		end
		if (ctrl.step_en && ctrl.word.emit) begin
			out_data_q <= acc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.step_en && ctrl.word.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid       = out_valid_q;
	assign variate         = out_data_q;
	assign status.cnt_zero = (cnt_q == '0);
	assign status.out_full = out_valid_q && !out_ready;

endmodule

>>> rtl/lcg_random_variate_generator.sv
// ----------------------------------------------------------------------------
// lcg_random_variate_generator
// Linear congruential generator drawing uniform, triangular, power-maximum
// and approximate normal variates in fixed point with 32 fraction bits.
// ----------------------------------------------------------------------------
// The request channel (s_*) carries the mode in s_tuser and a seed in
// s_tdata; the result channel (m_*) carries the variate in m_tdata. The
// register power_order is written through cfg_we and cfg_wdata; the user
// must write it only while idle, which the block itself does not enforce.
// A request is taken only while the microcode sequencer is idle, so one
// item occupies the block until its program has run its final step, and a
// power item runs longer as power_order grows. Each draw is one pass
// through the 32 by 32 bit state multiplier. The result is registered at
// the final program step and appears in the cycle after that step. Unused
// modes are accepted and dropped. If the receiver stalls, the result stays
// in the output register; the next request is still taken and runs until
// it reaches its result step, where it waits until the register is free.
// Reset sets the generator state to one, power_order to zero and leaves
// the block idle with no result pending.
// ----------------------------------------------------------------------------
module lcg_random_variate_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // seed_value [31:0]
	input  logic [2:0]  s_tuser,   // mode [2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // variate [35:0], zero [39:36]
);

	logic [lcg_pkg::COUNT_BITS-1:0]   power_order_q;
	logic [lcg_pkg::VARIATE_BITS-1:0] variate;
	lcg_pkg::seq_ctrl_t               ctrl;
	lcg_pkg::dp_status_t              status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_order_q <= '0;
		end else if (cfg_we) begin
			power_order_q <= cfg_wdata;
		end
	end

	lcg_sequencer u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_mode  (s_tuser),
		.req_ready (s_tready),
		.status    (status),
		.ctrl      (ctrl)
	);

	lcg_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.seed_value  (s_tdata),
		.power_order (power_order_q),
		.out_ready   (m_tready),
		.out_valid   (m_tvalid),
		.variate     (variate),
		.status      (status)
	);

	assign m_tdata = {4'b0000, variate};

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the linear congruential variate generator. A
// local model of the generator state and of power_order predicts every
// variate. Requests go in on the slave stream and variates are compared
// in order on the master stream. Directed items cover every mode, the
// reseed extremes and the unused modes, and random phases follow at several
// power orders, with random gaps on both sides and a final stretch without
// gaps.
// ----------------------------------------------------------------------------
module tb_top;

	localparam logic [31:0] STEP_MULT     = 32'd1566083941;
	localparam logic [31:0] STEP_INC      = 32'd1;
	localparam logic [31:0] SEED_AT_RESET = 32'd1;
	localparam logic [35:0] NORMAL_SHIFT  = 36'h6_0000_0000;
	localparam int          NORMAL_TERMS  = 12;
	localparam logic [2:0]  MODE_SPARE_LO = 3'd5;
	localparam logic [2:0]  MODE_SPARE_HI = 3'd7;
	localparam int          SETTLE_CYCLES = 32;
	localparam int          STALL_LIMIT   = 4000;
	localparam int          REPORT_LIMIT  = 10;

	typedef struct {
		logic [2:0]  mode;
		logic [35:0] variate;
	} variate_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [7:0]  cfg_wdata = 8'd0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata   = 32'd0;
	logic [2:0]  s_tuser   = 3'd0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [39:0] m_tdata;

	logic [31:0] gen_state  = SEED_AT_RESET;
	logic [7:0]  draw_order = 8'd0;
	variate_t    pending_variates[$];
	int          mismatch_count = 0;
	int          sent_count     = 0;
	int          quiet_cycles   = 0;
	int          ready_hold     = 0;
	int          gap_pct        = 25;
	bit          idle_on        = 1'b1;

	lcg_random_variate_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #6 clk = ~clk;

	function automatic logic [35:0] draw_fraction();
		gen_state = gen_state * STEP_MULT + STEP_INC;
		return {4'b0000, gen_state};
	endfunction

	function automatic bit predict_variate(input logic [2:0] mode, input logic [31:0] seed,
			output logic [35:0] v);
		logic [35:0] a;
		v = '0;
		case (mode)
			lcg_pkg::MODE_UNIFORM: begin
				v = draw_fraction();
			end
			lcg_pkg::MODE_TRIANGULAR: begin
				a = draw_fraction();
				v = a - draw_fraction();
			end
			lcg_pkg::MODE_POWER: begin
				v = draw_fraction();
				for (int i = 0; i < draw_order; i++) begin
					a = draw_fraction();
					if (a > v) begin
						v = a;
					end
				end
			end
			lcg_pkg::MODE_NORMAL: begin
				for (int i = 0; i < NORMAL_TERMS; i++) begin
					v = v + draw_fraction();
				end
				v = v - NORMAL_SHIFT;
			end
			lcg_pkg::MODE_RESEED: begin
				gen_state = seed;
				return 1'b0;
			end
			default: begin
				return 1'b0;
			end
		endcase
		return 1'b1;
	endfunction

	function automatic logic [2:0] random_mode();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 25) return lcg_pkg::MODE_UNIFORM;
		if (pick < 50) return lcg_pkg::MODE_TRIANGULAR;
		if (pick < 70) return lcg_pkg::MODE_POWER;
		if (pick < 85) return lcg_pkg::MODE_NORMAL;
		if (pick < 95) return lcg_pkg::MODE_RESEED;
		return 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_request(input logic [2:0] mode, input logic [31:0] seed);
		variate_t    exp_item;
		logic [35:0] v;
		if (idle_on && $urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= seed;
		do @(posedge clk); while (!s_tready);
		if (mode <= lcg_pkg::MODE_RESEED) begin
			sent_count++;
		end
		if (predict_variate(mode, seed, v)) begin
			exp_item.mode    = mode;
			exp_item.variate = v;
			pending_variates.push_back(exp_item);
		end
		@(negedge clk);
	endtask

	// A reseed or an unused mode may still be in flight once the queue is empty.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_variates.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_power_order(input logic [7:0] order);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= order;
		@(negedge clk);
		cfg_we     <= 1'b0;
		draw_order  = order;
	endtask

	task automatic run_random_requests(input int count);
		int target;
		target = sent_count + count;
		while (sent_count < target) begin
			send_request(random_mode(), $urandom());
		end
	endtask

	task automatic test_directed_modes();
		send_request(lcg_pkg::MODE_UNIFORM, 32'h0);
		send_request(lcg_pkg::MODE_TRIANGULAR, 32'h0);
		send_request(lcg_pkg::MODE_POWER, 32'h0);
		send_request(lcg_pkg::MODE_NORMAL, 32'h0);
		for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++) begin
			send_request(3'(m), 32'hFFFF_FFFF);
		end
		send_request(lcg_pkg::MODE_RESEED, 32'h0000_0000);
		send_request(lcg_pkg::MODE_UNIFORM, 32'h0);
		send_request(lcg_pkg::MODE_TRIANGULAR, 32'h0);
		send_request(lcg_pkg::MODE_RESEED, 32'hFFFF_FFFF);
		send_request(lcg_pkg::MODE_UNIFORM, 32'h0);
		send_request(lcg_pkg::MODE_NORMAL, 32'h0);
		send_request(lcg_pkg::MODE_RESEED, 32'hAAAA_AAAA);
		send_request(lcg_pkg::MODE_POWER, 32'h5555_5555);
		send_request(lcg_pkg::MODE_RESEED, 32'h5555_5555);
		send_request(lcg_pkg::MODE_TRIANGULAR, 32'hAAAA_AAAA);
		send_request(lcg_pkg::MODE_NORMAL, 32'h0);
		set_power_order(8'd255);
		send_request(lcg_pkg::MODE_POWER, 32'h0);
		send_request(lcg_pkg::MODE_UNIFORM, 32'h0);
		set_power_order(8'd1);
		send_request(lcg_pkg::MODE_POWER, 32'h0);
		send_request(lcg_pkg::MODE_TRIANGULAR, 32'h0);
	endtask

	task automatic test_power_orders();
		logic [7:0] orders[5];
		orders = '{8'd0, 8'd1, 8'd255, 8'd128, 8'($urandom_range(0, 255))};
		foreach (orders[k]) begin
			set_power_order(orders[k]);
			for (int n = 0; n < 5; n++) begin
				send_request(lcg_pkg::MODE_POWER, $urandom());
				send_request(($urandom_range(0, 1) != 0) ?
					lcg_pkg::MODE_UNIFORM : lcg_pkg::MODE_RESEED,
					$urandom());
			end
		end
	endtask

	task automatic test_random_mix();
		for (int ph = 0; ph < 6; ph++) begin
			gap_pct = (ph % 3 == 1) ? 0 : ((ph % 3 == 0) ? 30 : 60);
			if (ph == 3) begin
				set_power_order(8'd255);
				run_random_requests(40);
			end else begin
				set_power_order(8'($urandom_range(0, 15)));
				run_random_requests(230);
			end
		end
	endtask

	task automatic test_back_to_back();
		set_power_order(8'($urandom_range(0, 7)));
		idle_on = 1'b0;
		run_random_requests(300);
	endtask

	always @(negedge clk) begin
		logic ready_next;
		if (ready_hold > 0) begin
			ready_hold--;
			ready_next = 1'b0;
		end else if (idle_on && $urandom_range(0, 99) < gap_pct) begin
			ready_hold = $urandom_range(0, 3);
			ready_next = 1'b0;
		end else begin
			ready_next = 1'b1;
		end
		m_tready <= ready_next;
	end

	always @(posedge clk) begin
		variate_t exp_item;
		if (m_tvalid && m_tready) begin
			if (pending_variates.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT) begin
					$display("%t: unexpected item %h", $realtime, m_tdata);
				end
			end else begin
				exp_item = pending_variates.pop_front();
				if (m_tdata !== {4'b0000, exp_item.variate}) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT) begin
						$display("%t: mode %0d expected %h got %h", $realtime,
							exp_item.mode, {4'b0000, exp_item.variate}, m_tdata);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%t: watchdog expired, %0d items outstanding", $realtime,
					pending_variates.size());
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed_modes();
		test_power_orders();
		test_random_mix();
		test_back_to_back();
		drain_results();
		mismatch_count += pending_variates.size();
		if (mismatch_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/lcg_pkg.sv
rtl/lcg_sequencer.sv
rtl/lcg_datapath.sv
rtl/lcg_random_variate_generator.sv
tb/sv/tb_top.sv
